// ----- rtl/d2s_pkg.sv -----
// Shared types, constants and the month table of the date-to-seconds counter.
package d2s_pkg;

	// Field widths of the item channels
	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int HOUR_W  = 5;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int HALF_W  = 32;
	localparam int STAMP_W = 2 * HALF_W;

	// Shared multiply-add unit: p = a * b + c
	localparam int MAC_A_W = 23;
	localparam int MAC_B_W = 17;
	localparam int MAC_P_W = MAC_A_W + MAC_B_W;

	// Day table entries fit in nine bits (largest is 365)
	localparam int DBM_W = 9;

	// year / 100 as (year * 5243) >> 19, exact for every 14-bit year
	localparam int                 Q100_W       = 8;
	localparam int                 DIV100_SHIFT = 19;
	localparam logic [MAC_B_W-1:0] DIV100_RECIP = 17'd5243;

	localparam logic [MAC_B_W-1:0] HUNDRED       = 17'd100;
	localparam logic [MAC_B_W-1:0] DAYS_PER_YEAR = 17'd365;
	localparam logic [MAC_B_W-1:0] SIXTY         = 17'd60;
	localparam logic [MAC_B_W-1:0] SECS_PER_DAY  = 17'd86400;

	// Request kinds
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_TICK = 1'b1
	} req_kind_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} req_item_t;

	typedef struct packed {
		logic [HALF_W-1:0] stamp_high;
		logic [HALF_W-1:0] stamp_low;
	} rsp_item_t;

	// Operands handed to the shared unit
	typedef struct packed {
		logic [MAC_A_W-1:0] a;
		logic [MAC_B_W-1:0] b;
		logic [MAC_P_W-1:0] c;
	} mac_op_t;

	// Days before the month; codes above December give a full year
	function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
		logic [DBM_W-1:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/d2s_chan_if.sv -----
// Valid/ready channel carrying one item of a given payload type.
interface d2s_chan_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/date_to_seconds_timestamp_counter_core.sv -----
// A 64-bit seconds counter. A tick item adds one; a load item replaces the count with
// the seconds of a calendar date and time (days = year*365 + year/4 - year/100 +
// year/400 + days before the month + day, plus one past February in a leap year,
// times 86400, plus hour, minute and second). Every item returns the new count as
// two 32-bit halves. One item is handled at a time: a tick goes from the accept straight to
// the write state; a load runs six passes through a single registered 23x17 multiply-add
// unit and then the write state. The result sits in an output register, so the next item
// is taken while it waits; the write of a new result waits only if the previous one is
// still untaken, and the unit holds the loaded count for as long as that lasts.
module date_to_seconds_timestamp_counter_core (
	input logic        clk,
	input logic        arst_n,
	d2s_chan_if.sink   req,
	d2s_chan_if.source rsp
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DIV  = 8'b0000_0010,
		ST_CHK  = 8'b0000_0100,
		ST_DAYS = 8'b0000_1000,
		ST_HMS1 = 8'b0001_0000,
		ST_HMS2 = 8'b0010_0000,
		ST_SECS = 8'b0100_0000,
		ST_FIN  = 8'b1000_0000
	} state_t;

	state_t                         state_q;
	d2s_pkg::req_item_t             item_q;
	logic [d2s_pkg::Q100_W-1:0]     q100_q;
	logic [d2s_pkg::MAC_A_W-1:0]    days_q;
	logic [d2s_pkg::STAMP_W-1:0]    stamp_q;
	logic                           rsp_valid_q;
	d2s_pkg::rsp_item_t             rsp_data_q;

	d2s_pkg::mac_op_t               mac_op;
	logic [d2s_pkg::MAC_P_W-1:0]    mac_p;

	logic                           req_fire;
	logic                           slot_free;
	logic                           fin_fire;
	logic [d2s_pkg::Q100_W-1:0]     q100_now;
	logic                           century;
	logic                           leap;
	logic [d2s_pkg::MAC_P_W-1:0]    days_addend;
	logic [d2s_pkg::STAMP_W-1:0]    stamp_next;

	d2s_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.p_q (mac_p)
	);

	// Handshake
	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign slot_free  = !rsp_valid_q || rsp.ready;
	assign fin_fire   = (state_q == ST_FIN) && slot_free;
	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_data_q;

	// Quotient of year / 100 from the reciprocal product
	assign q100_now = mac_p[d2s_pkg::DIV100_SHIFT +: d2s_pkg::Q100_W];

	// Leap year: divisible by 4, and not a century unless divisible by 400
	assign century = (mac_p == d2s_pkg::MAC_P_W'(item_q.year));
	assign leap    = (item_q.year[1:0] == 2'b00) && (!century || (q100_q[1:0] == 2'b00));

	// Everything in the day count except year * 365
	always_comb begin
		days_addend = d2s_pkg::MAC_P_W'(item_q.year >> 2)
			- d2s_pkg::MAC_P_W'(q100_q)
			+ d2s_pkg::MAC_P_W'(q100_q >> 2)
			+ d2s_pkg::MAC_P_W'(d2s_pkg::days_before_month(item_q.month))
			+ d2s_pkg::MAC_P_W'(item_q.day)
			+ d2s_pkg::MAC_P_W'(leap && (item_q.month > 4'd2));
	end

	// Operand selection for the shared unit, one pass per state
	always_comb begin
		mac_op = '0;
		case (state_q)
			ST_DIV: begin
				mac_op.a = d2s_pkg::MAC_A_W'(item_q.year);
				mac_op.b = d2s_pkg::DIV100_RECIP;
			end
			ST_CHK: begin
				mac_op.a = d2s_pkg::MAC_A_W'(q100_now);
				mac_op.b = d2s_pkg::HUNDRED;
			end
			ST_DAYS: begin
				mac_op.a = d2s_pkg::MAC_A_W'(item_q.year);
				mac_op.b = d2s_pkg::DAYS_PER_YEAR;
				mac_op.c = days_addend;
			end
			ST_HMS1: begin
				mac_op.a = d2s_pkg::MAC_A_W'(item_q.hour);
				mac_op.b = d2s_pkg::SIXTY;
				mac_op.c = d2s_pkg::MAC_P_W'(item_q.minute);
			end
			ST_HMS2: begin
				mac_op.a = mac_p[d2s_pkg::MAC_A_W-1:0];
				mac_op.b = d2s_pkg::SIXTY;
				mac_op.c = d2s_pkg::MAC_P_W'(item_q.second);
			end
			ST_SECS: begin
				mac_op.a = days_q;
				mac_op.b = d2s_pkg::SECS_PER_DAY;
				mac_op.c = mac_p;
			end
			ST_FIN: begin
				// Recirculate the loaded count while the write waits
				mac_op.c = mac_p;
			end
			default: begin
				mac_op = '0;
			end
		endcase
	end

	// New count: loaded seconds or one more
	assign stamp_next = (item_q.req_type == d2s_pkg::REQ_LOAD)
		? d2s_pkg::STAMP_W'(mac_p) : stamp_q + d2s_pkg::STAMP_W'(1);

	// Sequencer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			stamp_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fin_fire) begin
				stamp_q     <= stamp_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= (req.data.req_type == d2s_pkg::REQ_TICK) ? ST_FIN : ST_DIV;
					end
				end
				ST_DIV:  state_q <= ST_CHK;
				ST_CHK:  state_q <= ST_DAYS;
				ST_DAYS: state_q <= ST_HMS1;
				ST_HMS1: state_q <= ST_HMS2;
				ST_HMS2: state_q <= ST_SECS;
				ST_SECS: state_q <= ST_FIN;
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req.data;
		end
		if (state_q == ST_CHK) begin
			q100_q <= q100_now;
		end
		if (state_q == ST_HMS1) begin
			days_q <= mac_p[d2s_pkg::MAC_A_W-1:0];
		end
		if (fin_fire) begin
			rsp_data_q <= stamp_next;
		end
	end

endmodule

// ----- rtl/d2s_mac.sv -----
// Shared multiply-add unit with registered result.
module d2s_mac (
	input  logic                          clk,
	input  d2s_pkg::mac_op_t              op,
	output logic [d2s_pkg::MAC_P_W-1:0]   p_q
);

	logic [d2s_pkg::MAC_P_W-1:0] prod;

	// a * b at full width, c added on top
	assign prod = {{d2s_pkg::MAC_B_W{1'b0}}, op.a} * {{d2s_pkg::MAC_A_W{1'b0}}, op.b};

	always_ff @(posedge clk) begin
		p_q <= prod + op.c;
	end

endmodule

// ----- rtl/d2s_checker.sv -----
// Port-level checks on the date-to-seconds counter, bound to its top level.
module d2s_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          req_type,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [d2s_pkg::STAMP_W-1:0]   rsp_data
);

	logic req_acc;

	assign req_acc = req_valid && req_ready;

	// One item at a time: no new item straight after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("item accepted on the cycle after another");

	// A load keeps the block busy through all its unit passes
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req_type == d2s_pkg::REQ_LOAD)) |=>
		!req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready ##1 !req_ready
		##1 !req_ready)
		else $error("load finished too early");

	// A fresh result only ever follows a busy cycle
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared without an item in progress");

	// Stalled result holds its value
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled result changed");

endmodule

bind date_to_seconds_timestamp_counter_core d2s_checker u_d2s_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.data.req_type),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
